// File: hw/rtl/body_frame_velocity_command_assert.svh
// Assertion macros for the velocity command block
`ifndef BODY_FRAME_VELOCITY_COMMAND_ASSERT_SVH
`define BODY_FRAME_VELOCITY_COMMAND_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge outside reset
`define BFVC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check a consequent in the same cycle as its antecedent
`define BFVC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define BFVC_ASSERT_ALWAYS(label, cond, msg)
`define BFVC_ASSERT_IMPLY(label, ante, cons, msg)

`endif

`endif

// File: hw/rtl/bfvc_pkg.sv
package bfvc_pkg;

  // Sizing of the datapath
  localparam int POSITION_BITS = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int STAGE_BITS    = $clog2(NUM_STAGES);

  localparam int HEADING_W = 16;
  localparam int ANG_SHIFT = 17;
  localparam int ANG_W     = 34;
  localparam int DIFF_W    = POSITION_BITS + 1;
  localparam int TRIG_W    = 32;
  localparam int SPEED_W   = 16;
  localparam int DB_W      = 12;
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 15;

  // Angles in units of 2^-30 rad, CORDIC vectors in Q1.30
  localparam logic signed [ANG_W-1:0] CORDIC_X0   = 34'sd652032874;
  localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] ANG_PI      = 34'sd3373259426;

  // Floor-rounded atan(2^-i)
  localparam logic signed [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6, 34'sh03FEAB76,
    34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55, 34'sh003FFFEA, 34'sh001FFFFD,
    34'sh000FFFFF, 34'sh0007FFFF, 34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF,
    34'sh00007FFF, 34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
    34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F
  };

  // Register map
  typedef enum logic [1:0] {
    REG_FORWARD_DEADBAND,
    REG_LATERAL_DEADBAND,
    REG_SPEED_GAIN,
    REG_SPEED_LIMIT
  } reg_idx_t;

  localparam logic [DB_W-1:0]    FORWARD_DEADBAND_RST = 12'd30;
  localparam logic [DB_W-1:0]    LATERAL_DEADBAND_RST = 12'd300;
  localparam logic [GAIN_W-1:0]  SPEED_GAIN_RST       = 16'd45875;
  localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST      = 15'd32767;

  // Configuration handed to the scaling pipeline
  typedef struct packed {
    logic [DB_W-1:0]    forward_deadband;
    logic [DB_W-1:0]    lateral_deadband;
    logic [GAIN_W-1:0]  speed_gain;
    logic [LIMIT_W-1:0] speed_limit;
  } cfg_t;

  // Data carried along the CORDIC row
  typedef struct packed {
    logic signed [ANG_W-1:0]  x;
    logic signed [ANG_W-1:0]  y;
    logic signed [ANG_W-1:0]  z;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic                     neg;
  } cordic_t;

  function automatic logic signed [ANG_W-1:0] atan_entry(input logic [STAGE_BITS-1:0] idx);
    return ATAN_TAB[idx];
  endfunction

endpackage

// File: hw/rtl/bfvc_cmd_if.sv
interface bfvc_cmd_if;
  import bfvc_pkg::*;

  logic                            valid;
  logic                            ready;
  logic signed [POSITION_BITS-1:0] robot_pos_x;
  logic signed [POSITION_BITS-1:0] robot_pos_y;
  logic signed [POSITION_BITS-1:0] target_pos_x;
  logic signed [POSITION_BITS-1:0] target_pos_y;
  logic signed [HEADING_W-1:0]     heading;

  modport source (
    output valid, robot_pos_x, robot_pos_y, target_pos_x, target_pos_y, heading,
    input  ready
  );

  modport sink (
    input  valid, robot_pos_x, robot_pos_y, target_pos_x, target_pos_y, heading,
    output ready
  );
endinterface

// File: hw/rtl/bfvc_speed_if.sv
interface bfvc_speed_if;
  import bfvc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] forward_speed;
  logic signed [SPEED_W-1:0] lateral_speed;

  modport source (
    output valid, forward_speed, lateral_speed,
    input  ready
  );

  modport sink (
    input  valid, forward_speed, lateral_speed,
    output ready
  );
endinterface

// File: hw/rtl/bfvc_cordic_cell.sv
module bfvc_cordic_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [bfvc_pkg::STAGE_BITS-1:0] stage,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  bfvc_pkg::cordic_t              up_data,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output bfvc_pkg::cordic_t              dn_data
);
  import bfvc_pkg::*;

  logic signed [ANG_W-1:0] x_sh;
  logic signed [ANG_W-1:0] y_sh;
  logic signed [ANG_W-1:0] atan;
  cordic_t                 rotated;

  // Rotate by one micro-angle towards zero residual angle
  always_comb begin
    x_sh    = $signed(up_data.x) >>> stage;
    y_sh    = $signed(up_data.y) >>> stage;
    atan    = atan_entry(stage);
    rotated = up_data;
    if (!up_data.z[ANG_W-1]) begin
      rotated.x = up_data.x - y_sh;
      rotated.y = up_data.y + x_sh;
      rotated.z = up_data.z - atan;
    end else begin
      rotated.x = up_data.x + y_sh;
      rotated.y = up_data.y - x_sh;
      rotated.z = up_data.z + atan;
    end
  end

  // Advance when the neighbour takes the held item or the cell is empty
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      dn_data <= rotated;
    end
  end

endmodule

// File: hw/rtl/bfvc_speed.sv
module bfvc_speed (
  input  logic                              clk,
  input  logic                              rst,
  input  bfvc_pkg::cfg_t                    cfg,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  bfvc_pkg::cordic_t                 up_data,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output logic signed [bfvc_pkg::SPEED_W-1:0] forward_speed,
  output logic signed [bfvc_pkg::SPEED_W-1:0] lateral_speed
);
  import bfvc_pkg::*;

  localparam int NSTG       = 6;
  localparam int DSQ_W      = 2 * DIFF_W;
  localparam int D2_W       = DSQ_W + 1;
  localparam int PROD_W     = DIFF_W + TRIG_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int MAG_SHIFT  = 14;
  localparam int MAG_W      = SUM_W - MAG_SHIFT;
  localparam int SCALED_W   = MAG_W + GAIN_W;
  localparam int ROUND_W    = SCALED_W + 1;
  localparam int DIV_SHIFT  = 16;
  localparam int M_W        = ROUND_W - DIV_SHIFT;
  localparam int M_LOW_W    = 26;
  localparam int RECIP_W    = 27;
  localparam int QUO_W      = M_LOW_W + RECIP_W;
  localparam int RECIP_SHIFT = 37;

  // Rounding offset 2000*2^15, clamp threshold 2000*2^15 after the shift by 16,
  // reciprocal ceil(2^37/2000), exact for quotients below 2^15
  localparam logic [ROUND_W-1:0] ROUND_HALF = ROUND_W'(65536000);
  localparam logic [M_W-1:0]     CLAMP_M    = M_W'(65536000);
  localparam logic [RECIP_W-1:0] RECIP      = RECIP_W'(68719477);

  logic [NSTG-1:0] vld;
  logic [NSTG:0]   rdy;
  logic [NSTG-1:0] vld_in;

  // Stage ready chain: a stage loads when empty or when its successor loads
  always_comb begin
    rdy[NSTG] = dn_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign vld_in   = {vld[NSTG-2:0], up_valid};
  assign up_ready = rdy[0];
  assign dn_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  // Stage 1: fold quadrant sign into sin and cos, square the offsets
  logic signed [TRIG_W-1:0] s1_cs;
  logic signed [TRIG_W-1:0] s1_sn;
  logic signed [DIFF_W-1:0] s1_dx;
  logic signed [DIFF_W-1:0] s1_dy;
  logic [DSQ_W-1:0]         s1_dsq_x;
  logic [DSQ_W-1:0]         s1_dsq_y;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_cs    <= TRIG_W'(up_data.neg ? -up_data.x : up_data.x);
      s1_sn    <= TRIG_W'(up_data.neg ? -up_data.y : up_data.y);
      s1_dx    <= up_data.dx;
      s1_dy    <= up_data.dy;
      s1_dsq_x <= DSQ_W'(up_data.dx * up_data.dx);
      s1_dsq_y <= DSQ_W'(up_data.dy * up_data.dy);
    end
  end

  // Stage 2: four rotation products and the squared distance
  logic signed [PROD_W-1:0] s2_dx_cs;
  logic signed [PROD_W-1:0] s2_dy_sn;
  logic signed [PROD_W-1:0] s2_dy_cs;
  logic signed [PROD_W-1:0] s2_dx_sn;
  logic [D2_W-1:0]          s2_d2;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s2_dx_cs <= PROD_W'(s1_dx * s1_cs);
      s2_dy_sn <= PROD_W'(s1_dy * s1_sn);
      s2_dy_cs <= PROD_W'(s1_dy * s1_cs);
      s2_dx_sn <= PROD_W'(s1_dx * s1_sn);
      s2_d2    <= D2_W'(s1_dsq_x) + D2_W'(s1_dsq_y);
    end
  end

  // Stage 3: body-frame sums and deadband tests
  logic signed [SUM_W-1:0] s3_pf;
  logic signed [SUM_W-1:0] s3_pl;
  logic                    s3_act_f;
  logic                    s3_act_l;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s3_pf    <= SUM_W'(s2_dx_cs) + SUM_W'(s2_dy_sn);
      s3_pl    <= SUM_W'(s2_dy_cs) - SUM_W'(s2_dx_sn);
      s3_act_f <= s2_d2 > (D2_W'(cfg.forward_deadband) * D2_W'(cfg.forward_deadband));
      s3_act_l <= s2_d2 > (D2_W'(cfg.lateral_deadband) * D2_W'(cfg.lateral_deadband));
    end
  end

  // Stage 4: magnitude, drop 14 fraction bits, apply gain
  logic [SUM_W-1:0]    mag_f;
  logic [SUM_W-1:0]    mag_l;
  logic [SCALED_W-1:0] s4_scaled_f;
  logic [SCALED_W-1:0] s4_scaled_l;
  logic                s4_neg_f;
  logic                s4_neg_l;
  logic                s4_act_f;
  logic                s4_act_l;

  always_comb begin
    mag_f = s3_pf[SUM_W-1] ? SUM_W'(-s3_pf) : SUM_W'(s3_pf);
    mag_l = s3_pl[SUM_W-1] ? SUM_W'(-s3_pl) : SUM_W'(s3_pl);
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s4_scaled_f <= SCALED_W'(mag_f[SUM_W-1:MAG_SHIFT]) * SCALED_W'(cfg.speed_gain);
      s4_scaled_l <= SCALED_W'(mag_l[SUM_W-1:MAG_SHIFT]) * SCALED_W'(cfg.speed_gain);
      s4_neg_f    <= s3_pf[SUM_W-1];
      s4_neg_l    <= s3_pl[SUM_W-1];
      s4_act_f    <= s3_act_f;
      s4_act_l    <= s3_act_l;
    end
  end

  // Stage 5: round, flag overrange, multiply by reciprocal of 2000
  logic [ROUND_W-1:0] rnd_f;
  logic [ROUND_W-1:0] rnd_l;
  logic [M_W-1:0]     m_f;
  logic [M_W-1:0]     m_l;
  logic [QUO_W-1:0]   s5_quo_f;
  logic [QUO_W-1:0]   s5_quo_l;
  logic               s5_big_f;
  logic               s5_big_l;
  logic               s5_neg_f;
  logic               s5_neg_l;
  logic               s5_act_f;
  logic               s5_act_l;

  always_comb begin
    rnd_f = ROUND_W'(s4_scaled_f) + ROUND_HALF;
    rnd_l = ROUND_W'(s4_scaled_l) + ROUND_HALF;
    m_f   = rnd_f[ROUND_W-1:DIV_SHIFT];
    m_l   = rnd_l[ROUND_W-1:DIV_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s5_quo_f <= QUO_W'(m_f[M_LOW_W-1:0]) * QUO_W'(RECIP);
      s5_quo_l <= QUO_W'(m_l[M_LOW_W-1:0]) * QUO_W'(RECIP);
      s5_big_f <= m_f >= CLAMP_M;
      s5_big_l <= m_l >= CLAMP_M;
      s5_neg_f <= s4_neg_f;
      s5_neg_l <= s4_neg_l;
      s5_act_f <= s4_act_f;
      s5_act_l <= s4_act_l;
    end
  end

  // Stage 6: clamp, restore sign, zero inside the deadband
  function automatic logic signed [SPEED_W-1:0] finish(
    input logic [QUO_W-1:0]   quo,
    input logic               big,
    input logic               neg,
    input logic               act,
    input logic [LIMIT_W-1:0] limit
  );
    logic [LIMIT_W-1:0] q;
    logic [LIMIT_W-1:0] qc;
    q  = quo[RECIP_SHIFT +: LIMIT_W];
    qc = (big || (q > limit)) ? limit : q;
    if (!act) begin
      return '0;
    end
    return neg ? -SPEED_W'(qc) : SPEED_W'(qc);
  endfunction

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      forward_speed <= finish(s5_quo_f, s5_big_f, s5_neg_f, s5_act_f, cfg.speed_limit);
      lateral_speed <= finish(s5_quo_l, s5_big_l, s5_neg_l, s5_act_l, cfg.speed_limit);
    end
  end

endmodule

// File: hw/rtl/body_frame_velocity_command.sv
// Body-frame velocity command. Each command transfer carries robot and target
// positions (signed mm) and the robot heading (Q2.13 rad); the block rotates the
// target offset into the robot frame with a pipelined CORDIC row, scales each
// axis by speed_gain/2000, clamps the magnitude to speed_limit and zeroes an
// axis whose target distance is within its deadband. One command is taken per
// clock while the pipeline does not stall; a result passes one entry stage,
// NUM_STAGES CORDIC cells and six scaling stages. Each stage moves on as
// soon as the next one is free, so the command side keeps transferring
// while a result waits at the output, until the pipeline is full. Registers
// sit at byte addresses 0, 4, 8 and 12 of the APB port and should be
// written only while no command is in flight.
`include "body_frame_velocity_command_assert.svh"

module body_frame_velocity_command (
  input  logic        clk,
  input  logic        rst,
  bfvc_cmd_if.sink    cmd,
  bfvc_speed_if.source speed,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bfvc_pkg::*;

  cfg_t cfg;

  // Configuration registers
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.forward_deadband <= FORWARD_DEADBAND_RST;
      cfg.lateral_deadband <= LATERAL_DEADBAND_RST;
      cfg.speed_gain       <= SPEED_GAIN_RST;
      cfg.speed_limit      <= SPEED_LIMIT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_FORWARD_DEADBAND: cfg.forward_deadband <= pwdata[DB_W-1:0];
        REG_LATERAL_DEADBAND: cfg.lateral_deadband <= pwdata[DB_W-1:0];
        REG_SPEED_GAIN:       cfg.speed_gain       <= pwdata[GAIN_W-1:0];
        REG_SPEED_LIMIT:      cfg.speed_limit      <= pwdata[LIMIT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_FORWARD_DEADBAND: prdata = 32'(cfg.forward_deadband);
      REG_LATERAL_DEADBAND: prdata = 32'(cfg.lateral_deadband);
      REG_SPEED_GAIN:       prdata = 32'(cfg.speed_gain);
      REG_SPEED_LIMIT:      prdata = 32'(cfg.speed_limit);
    endcase
  end

  // Entry stage: offsets, heading in CORDIC angle units, quadrant fold
  cordic_t                 entry_next;
  logic signed [ANG_W-1:0] z_raw;
  logic                    entry_valid;
  cordic_t                 entry;

  cordic_t                 link_data  [NUM_STAGES+1];
  logic [NUM_STAGES:0]     link_valid;
  logic [NUM_STAGES:0]     link_ready;

  always_comb begin
    z_raw         = {{(ANG_W - HEADING_W - ANG_SHIFT){cmd.heading[HEADING_W-1]}},
                     cmd.heading, {ANG_SHIFT{1'b0}}};
    entry_next.x  = CORDIC_X0;
    entry_next.y  = '0;
    entry_next.dx = {cmd.target_pos_x[POSITION_BITS-1], cmd.target_pos_x}
                  - {cmd.robot_pos_x[POSITION_BITS-1], cmd.robot_pos_x};
    entry_next.dy = {cmd.target_pos_y[POSITION_BITS-1], cmd.target_pos_y}
                  - {cmd.robot_pos_y[POSITION_BITS-1], cmd.robot_pos_y};
    priority if (z_raw > ANG_HALF_PI) begin
      entry_next.z   = z_raw - ANG_PI;
      entry_next.neg = 1'b1;
    end else if (z_raw < -ANG_HALF_PI) begin
      entry_next.z   = z_raw + ANG_PI;
      entry_next.neg = 1'b1;
    end else begin
      entry_next.z   = z_raw;
      entry_next.neg = 1'b0;
    end
  end

  assign cmd.ready = !entry_valid || link_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (cmd.ready) begin
      entry_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready) begin
      entry <= entry_next;
    end
  end

  assign link_data[0]  = entry;
  assign link_valid[0] = entry_valid;

  // Row of CORDIC cells, one micro-rotation each
  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
    bfvc_cordic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .stage    (STAGE_BITS'(g)),
      .up_valid (link_valid[g]),
      .up_ready (link_ready[g]),
      .up_data  (link_data[g]),
      .dn_valid (link_valid[g+1]),
      .dn_ready (link_ready[g+1]),
      .dn_data  (link_data[g+1])
    );
  end

  // Body-frame products, scaling, clamp and deadband
  bfvc_speed u_speed (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .up_valid      (link_valid[NUM_STAGES]),
    .up_ready      (link_ready[NUM_STAGES]),
    .up_data       (link_data[NUM_STAGES]),
    .dn_valid      (speed.valid),
    .dn_ready      (speed.ready),
    .forward_speed (speed.forward_speed),
    .lateral_speed (speed.lateral_speed)
  );

  // Checks
  logic signed [SPEED_W-1:0] speed_cap;
  logic                      fwd_in_limit;
  logic                      lat_in_limit;

  assign speed_cap    = $signed({1'b0, cfg.speed_limit});
  assign fwd_in_limit = (speed.forward_speed <= speed_cap)
                     && (speed.forward_speed >= -speed_cap);
  assign lat_in_limit = (speed.lateral_speed <= speed_cap)
                     && (speed.lateral_speed >= -speed_cap);

  `BFVC_ASSERT_IMPLY(a_fwd_limit, speed.valid, fwd_in_limit, "forward speed beyond limit")
  `BFVC_ASSERT_IMPLY(a_lat_limit, speed.valid, lat_in_limit, "lateral speed beyond limit")
  `BFVC_ASSERT_IMPLY(a_ready_when_drained, !speed.valid, cmd.ready, "command stalled with empty output stage")

endmodule

// File: bench/bfvc_command_checker.sv
`timescale 1ns / 1ps

// Watches the command and speed channels and the register port. Every command
// transfer gets its own predicted speed pair, and each speed transfer is
// compared with the oldest pair still waiting.
module bfvc_command_checker (
  input  logic        clk,
  input  logic        rst,
  bfvc_cmd_if         cmd,
  bfvc_speed_if       speed,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          failures,
  output int          speeds_pending
);
  import bfvc_pkg::*;

  // Angles in units of 2^-30 rad, rotation vector in Q1.30
  localparam longint ROT_X_START  = 64'sd652032874;
  localparam longint QUARTER_TURN = 64'sd1686629713;
  localparam longint HALF_TURN    = 64'sd3373259426;
  localparam int     ARCTAN_LEN   = 24;

  // Floor-rounded atan(2^-i)
  localparam longint ARCTAN_STEP [ARCTAN_LEN] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  typedef struct packed {
    logic signed [SPEED_W-1:0] fwd;
    logic signed [SPEED_W-1:0] lat;
  } speed_pair_t;

  // Shadow copy of the registers
  logic [DB_W-1:0]    fwd_deadband;
  logic [DB_W-1:0]    lat_deadband;
  logic [GAIN_W-1:0]  gain;
  logic [LIMIT_W-1:0] limit;

  speed_pair_t speeds_due[$];
  speed_pair_t want;
  int          fail_count = 0;
  int          in_flight  = 0;

  assign failures       = fail_count;
  assign speeds_pending = in_flight;

  // Rotation-mode CORDIC: fold the angle into a half turn, then iterate
  function automatic void heading_sin_cos(input longint angle, output longint sn,
                                          output longint cs);
    longint x, y, z, t;
    bit     flip;
    int     stages;
    x      = ROT_X_START;
    y      = 0;
    z      = angle;
    flip   = 1'b0;
    stages = (CORDIC_STAGES > ARCTAN_LEN) ? ARCTAN_LEN : CORDIC_STAGES;
    if (z > QUARTER_TURN) begin
      z    = z - HALF_TURN;
      flip = 1'b1;
    end else if (z < -QUARTER_TURN) begin
      z    = z + HALF_TURN;
      flip = 1'b1;
    end
    for (int i = 0; i < stages; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ARCTAN_STEP[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ARCTAN_STEP[i];
      end
      x = t;
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  // Scale by gain/2000 with half-up rounding, clamp, restore the sign
  function automatic logic signed [SPEED_W-1:0] axis_command(input longint p,
                                                             input bit active);
    longint unsigned mag, q;
    logic [SPEED_W-1:0] v;
    if (!active) return '0;
    mag = (p < 0) ? longint'(-p) : p;
    mag = mag >> 14;
    q   = (mag * longint'(gain) + 64'd65536000) / 64'd131072000;
    if (q > longint'(limit)) q = longint'(limit);
    v = q[SPEED_W-1:0];
    if (p < 0) v = -v;
    return v;
  endfunction

  function automatic speed_pair_t body_speeds_for(
    input logic signed [POSITION_BITS-1:0] rx, ry, tx, ty,
    input logic signed [HEADING_W-1:0]     hd
  );
    longint      dx, dy, dist2, sn, cs, pf, pl;
    speed_pair_t r;
    dx    = longint'(tx) - longint'(rx);
    dy    = longint'(ty) - longint'(ry);
    dist2 = dx * dx + dy * dy;
    heading_sin_cos(longint'(hd) * 131072, sn, cs);
    pf    = dx * cs + dy * sn;
    pl    = dy * cs - dx * sn;
    r.fwd = axis_command(pf, dist2 > longint'(fwd_deadband) * longint'(fwd_deadband));
    r.lat = axis_command(pl, dist2 > longint'(lat_deadband) * longint'(lat_deadband));
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fwd_deadband <= FORWARD_DEADBAND_RST;
      lat_deadband <= LATERAL_DEADBAND_RST;
      gain         <= SPEED_GAIN_RST;
      limit        <= SPEED_LIMIT_RST;
      speeds_due.delete();
      in_flight    <= 0;
    end else begin
      // Mirror register writes
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_FORWARD_DEADBAND: fwd_deadband <= pwdata[DB_W-1:0];
          REG_LATERAL_DEADBAND: lat_deadband <= pwdata[DB_W-1:0];
          REG_SPEED_GAIN:       gain         <= pwdata[GAIN_W-1:0];
          REG_SPEED_LIMIT:      limit        <= pwdata[LIMIT_W-1:0];
          default: ;
        endcase
      end

      // Predict on every command transfer
      if (cmd.valid && cmd.ready)
        speeds_due.push_back(body_speeds_for(cmd.robot_pos_x, cmd.robot_pos_y,
                                             cmd.target_pos_x, cmd.target_pos_y,
                                             cmd.heading));

      // Compare every speed transfer with the oldest prediction
      if (speed.valid && speed.ready) begin
        if (speeds_due.size() == 0) begin
          $display("%0t: speed transfer with nothing outstanding, forward %0d lateral %0d",
                   $time, speed.forward_speed, speed.lateral_speed);
          fail_count++;
        end else begin
          want = speeds_due.pop_front();
          if (speed.forward_speed !== want.fwd) begin
            $display("%0t: forward_speed expected %0d, got %0d",
                     $time, want.fwd, speed.forward_speed);
            fail_count++;
          end
          if (speed.lateral_speed !== want.lat) begin
            $display("%0t: lateral_speed expected %0d, got %0d",
                     $time, want.lat, speed.lateral_speed);
            fail_count++;
          end
        end
      end

      in_flight <= speeds_due.size();
    end
  end

endmodule

// File: bench/tb_body_frame_velocity_command.sv
`timescale 1ns / 1ps

module tb_body_frame_velocity_command;
  import bfvc_pkg::*;

  localparam int RANDOM_PHASES    = 9;
  localparam int ITEMS_PER_PHASE  = 55;
  localparam int TAIL_CYCLES      = 40;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          failures;
  int          speeds_pending;
  bit          quiet = 1'b0;

  bfvc_cmd_if   cmd_ch ();
  bfvc_speed_if speed_ch ();

  body_frame_velocity_command dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .speed   (speed_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bfvc_command_checker speed_check (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd_ch),
    .speed          (speed_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .failures       (failures),
    .speeds_pending (speeds_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up on a hung run
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

  // Idle cycles before a transfer; none at all while quiet
  function automatic int pick_gap();
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  // Speed side: stall at random, then hold ready until a transfer
  initial begin
    int stall;
    speed_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        speed_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      speed_ch.ready <= 1'b1;
      do @(posedge clk); while (!speed_ch.valid);
    end
  end

  // Setup then access; psel stays high across back-to-back writes
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_registers(input int fwd_db, lat_db, gain, limit);
    write_reg(REG_FORWARD_DEADBAND, fwd_db);
    write_reg(REG_LATERAL_DEADBAND, lat_db);
    write_reg(REG_SPEED_GAIN, gain);
    write_reg(REG_SPEED_LIMIT, limit);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_command(input logic signed [POSITION_BITS-1:0] rx, ry, tx, ty,
                              input logic signed [HEADING_W-1:0] hd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.robot_pos_x  <= rx;
    cmd_ch.robot_pos_y  <= ry;
    cmd_ch.target_pos_x <= tx;
    cmd_ch.target_pos_y <= ty;
    cmd_ch.heading      <= hd;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // Saturate a target coordinate to the position range
  function automatic logic signed [POSITION_BITS-1:0] clip_pos(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[POSITION_BITS-1:0];
  endfunction

  // Mostly targets near the robot, so many speeds stay below the clamp
  task automatic random_command();
    logic signed [POSITION_BITS-1:0] rx, ry, tx, ty;
    logic signed [HEADING_W-1:0]     hd;
    int kind, span;
    rx   = POSITION_BITS'($urandom);
    ry   = POSITION_BITS'($urandom);
    kind = $urandom_range(0, 9);
    span = (kind < 5) ? 400 : 3000;
    if (kind < 2) begin
      tx = POSITION_BITS'($urandom);
      ty = POSITION_BITS'($urandom);
    end else if (kind == 9) begin
      tx = rx;
      ty = ry;
    end else begin
      tx = clip_pos(int'(rx) + int'($urandom_range(0, 2 * span)) - span);
      ty = clip_pos(int'(ry) + int'($urandom_range(0, 2 * span)) - span);
    end
    if ($urandom_range(0, 15) == 0)
      hd = HEADING_W'($urandom);
    else
      hd = HEADING_W'(int'($urandom_range(0, 51472)) - 25736);
    send_command(rx, ry, tx, ty, hd);
  endtask

  // Count from the next edge so the latest transfer is included
  task automatic wait_drained();
    @(posedge clk);
    while (speeds_pending != 0) @(posedge clk);
  endtask

  initial begin
    int fd, ld, g, lim;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.robot_pos_x  <= '0;
    cmd_ch.robot_pos_y  <= '0;
    cmd_ch.target_pos_x <= '0;
    cmd_ch.target_pos_y <= '0;
    cmd_ch.heading      <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst     <= 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed commands under the reset register values
    send_command(0, 0, 1000, 0, 0);
    send_command(0, 0, 0, 1000, 0);
    // either side of the quarter-turn fold
    send_command(0, 0, 1000, 0, 12867);
    send_command(0, 0, 1000, 0, 12868);
    send_command(0, 0, 1000, 0, -12867);
    send_command(0, 0, 1000, 0, -12868);
    send_command(0, 0, 1000, -700, 25736);
    send_command(0, 0, -800, 600, -25736);
    // headings beyond a half turn
    send_command(100, -100, 600, 400, 32767);
    send_command(-100, 100, -600, -400, -32768);
    // zero offset, then distances on and just past each deadband
    send_command(5, 5, 5, 5, 1000);
    send_command(0, 0, 30, 0, 0);
    send_command(0, 0, 31, 0, 0);
    send_command(0, 0, 0, 300, 0);
    send_command(0, 0, 0, 301, 0);
    send_command(0, 0, 18, 24, 2000);
    send_command(0, 0, 180, 240, -3000);
    // full-scale offsets hit the clamp
    send_command(-32768, -32768, 32767, 32767, 0);
    send_command(32767, 32767, -32768, -32768, 6434);
    send_command(32767, -32768, -32768, 32767, -6434);
    send_command(0, 0, -1000, 5, 0);
    send_command(-20000, 15000, -19999, 15400, 9000);
    cmd_ch.valid <= 1'b0;
    wait_drained();

    // Random phases, each under its own register setting
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      fd  = $urandom_range(0, 500);
      ld  = $urandom_range(0, 1500);
      g   = $urandom_range(0, 65535);
      lim = $urandom_range(0, 32767);
      case (ph)
        0: begin fd = 0;    ld = 0;    g = 65535; lim = 32767; end
        1: begin fd = 4095; ld = 4095; g = 65535; lim = 32767; end
        2: g = 0;
        3: lim = 0;
        4: begin fd = 30;   ld = 300;  g = 45875; lim = 32767; end
        5: lim = $urandom_range(1, 2000);
        default: ;
      endcase
      set_registers(fd, ld, g, lim);
      quiet = (ph % 3 == 1);
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        random_command();
      cmd_ch.valid <= 1'b0;
      quiet = 1'b0;
      wait_drained();
    end

    // Let any stray result surface before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
